// ===== rtl/gcl_pkg.sv =====
// shared types, request and status codes for the grid cell list neighbor query unit
// no dependencies; imported by gcl_ctrl, gcl_dp and the top level
`default_nettype none

package gcl_pkg;

  // parameter defaults
  localparam int unsigned MaxParticlesDef = 4096;
  localparam int unsigned GridMaxDef      = 32;
  localparam int unsigned BatchLimitDef   = 64;

  // request types
  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_LOAD  = 3'd1;
  localparam logic [2:0] REQ_BUILD = 3'd2;
  localparam logic [2:0] REQ_QUERY = 3'd3;
  localparam logic [2:0] REQ_CONT  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_ID    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_BUILD = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  // configuration register indexes
  localparam logic CFG_SPAN = 1'b0;
  localparam logic CFG_GRID = 1'b1;

  localparam logic [15:0] SPAN_RST  = 16'd65535;
  localparam logic [5:0]  GRID_RST  = 6'd20;
  localparam logic [3:0]  STEP_IDLE = 4'd9;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [11:0] particle_index;
  } req_t;

  typedef struct packed {
    logic [11:0] neighbor_id;
    logic [1:0]  status;
    logic [12:0] particle_total;
    logic        last;
    logic        more_pending;
  } rsp_t;

  // kind of result loaded into the output register
  typedef enum logic [2:0] {
    RES_MID,
    RES_LAST_MORE,
    RES_LAST,
    RES_NONE,
    RES_BUILD,
    RES_ERR
  } res_e;

  typedef struct packed {
    logic cap;
    logic clr;
    logic mul;
    logic div;
    logic ld_wr;
    logic idx_clr;
    logic idx_inc;
    logic off_clr_wr;
    logic pc_rd_idx;
    logic off_rd_cnt;
    logic off_wr_cnt;
    logic off_rd_pre;
    logic off_wr_pre;
    logic fill_rd;
    logic sc_wr;
    logic build_fin;
    logic pc_rd_q;
    logic q_base;
    logic sk_adv;
    logic off_rd_s;
    logic off_rd_e;
    logic fetch;
    logic hold;
    logic out_ld;
    res_e kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       full;
    logic       q_ok;
    logic       c_ok;
    logic       div_done;
    logic       idx_eq_cnt;
    logic       clr_done;
    logic       pre_done;
    logic       step_idle;
    logic       on_grid;
    logic       found;
    logic       held_v;
    logic       at_limit;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/gcl_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module gcl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/gcl_ctrl.sv =====
// sequencer for load, build, query and continue requests
// depends on gcl_pkg (cmd_t, sts_t, request codes)
`default_nettype none

module gcl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gcl_pkg::sts_t sts_i,
  output gcl_pkg::cmd_t cmd_o
);

  import gcl_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_DIV   = 5'd2;
  localparam logic [4:0] S_LDWR  = 5'd3;
  localparam logic [4:0] S_BCLR  = 5'd4;
  localparam logic [4:0] S_CRD   = 5'd5;
  localparam logic [4:0] S_CRO   = 5'd6;
  localparam logic [4:0] S_CWR   = 5'd7;
  localparam logic [4:0] S_PRD   = 5'd8;
  localparam logic [4:0] S_PWR   = 5'd9;
  localparam logic [4:0] S_SRD   = 5'd10;
  localparam logic [4:0] S_SRF   = 5'd11;
  localparam logic [4:0] S_SWR   = 5'd12;
  localparam logic [4:0] S_QBASE = 5'd13;
  localparam logic [4:0] S_SK    = 5'd14;
  localparam logic [4:0] S_SKE   = 5'd15;
  localparam logic [4:0] S_SKCHK = 5'd16;
  localparam logic [4:0] S_FETCH = 5'd17;
  localparam logic [4:0] S_HOLD  = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0] state_q, state_d;
  res_e       kind_q, kind_d;
  cmd_t       cmd;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd     = '0;
    cmd.kind = RES_ERR;
    state_d = state_q;
    kind_d  = kind_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.cap = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.req_type)
          REQ_CLEAR: begin
            cmd.clr = 1'b1;
            state_d = S_IDLE;
          end
          REQ_LOAD: begin
            if (sts_i.full) begin
              kind_d  = RES_ERR;
              state_d = S_OUT;
            end else begin
              cmd.mul = 1'b1;
              state_d = S_DIV;
            end
          end
          REQ_BUILD: begin
            cmd.idx_clr = 1'b1;
            state_d     = S_BCLR;
          end
          REQ_QUERY: begin
            if (sts_i.q_ok) begin
              cmd.pc_rd_q = 1'b1;
              state_d     = S_QBASE;
            end else begin
              kind_d  = RES_ERR;
              state_d = S_OUT;
            end
          end
          REQ_CONT: begin
            if (sts_i.c_ok) begin
              state_d = S_SK;
            end else begin
              kind_d  = RES_ERR;
              state_d = S_OUT;
            end
          end
          default: begin
            kind_d  = RES_ERR;
            state_d = S_OUT;
          end
        endcase
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_LDWR;
        end
      end
      S_LDWR: begin
        cmd.ld_wr = 1'b1;
        state_d   = S_IDLE;
      end
      S_BCLR: begin
        cmd.off_clr_wr = 1'b1;
        if (sts_i.clr_done) begin
          cmd.idx_clr = 1'b1;
          state_d     = S_CRD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CRD: begin
        if (sts_i.idx_eq_cnt) begin
          cmd.idx_clr = 1'b1;
          state_d     = S_PRD;
        end else begin
          cmd.pc_rd_idx = 1'b1;
          state_d       = S_CRO;
        end
      end
      S_CRO: begin
        cmd.off_rd_cnt = 1'b1;
        state_d        = S_CWR;
      end
      S_CWR: begin
        cmd.off_wr_cnt = 1'b1;
        cmd.idx_inc    = 1'b1;
        state_d        = S_CRD;
      end
      S_PRD: begin
        cmd.off_rd_pre = 1'b1;
        state_d        = S_PWR;
      end
      S_PWR: begin
        cmd.off_wr_pre = 1'b1;
        if (sts_i.pre_done) begin
          cmd.idx_clr = 1'b1;
          state_d     = S_SRD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_PRD;
        end
      end
      S_SRD: begin
        if (sts_i.idx_eq_cnt) begin
          cmd.build_fin = 1'b1;
          kind_d        = RES_BUILD;
          state_d       = S_OUT;
        end else begin
          cmd.pc_rd_idx = 1'b1;
          state_d       = S_SRF;
        end
      end
      S_SRF: begin
        cmd.fill_rd = 1'b1;
        state_d     = S_SWR;
      end
      S_SWR: begin
        cmd.sc_wr   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_d     = S_SRD;
      end
      S_QBASE: begin
        cmd.q_base = 1'b1;
        state_d    = S_SK;
      end
      S_SK: begin
        if (sts_i.step_idle) begin
          kind_d  = sts_i.held_v ? RES_LAST : RES_NONE;
          state_d = S_OUT;
        end else if (!sts_i.on_grid) begin
          cmd.sk_adv = 1'b1;
        end else begin
          cmd.off_rd_s = 1'b1;
          state_d      = S_SKE;
        end
      end
      S_SKE: begin
        cmd.off_rd_e = 1'b1;
        state_d      = S_SKCHK;
      end
      S_SKCHK: begin
        if (sts_i.found) begin
          if (sts_i.held_v) begin
            kind_d  = sts_i.at_limit ? RES_LAST_MORE : RES_MID;
            state_d = S_OUT;
          end else begin
            state_d = S_FETCH;
          end
        end else begin
          cmd.sk_adv = 1'b1;
          state_d    = S_SK;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_d   = S_HOLD;
      end
      S_HOLD: begin
        cmd.hold = 1'b1;
        state_d  = S_SK;
      end
      S_OUT: begin
        cmd.kind = kind_q;
        if (sts_i.out_free) begin
          cmd.out_ld = 1'b1;
          state_d    = (kind_q == RES_MID) ? S_FETCH : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= RES_ERR;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // a request is only taken with the machine at rest
  a_cap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cap |=> (state_q == S_DISP))
    else $error("capture did not lead to dispatch");

  // a result load always leaves the output state
  a_out_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |=> (state_q == S_FETCH || state_q == S_IDLE))
    else $error("output state not left after load");

  // a middle result is only emitted while more ids follow
  a_mid_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_ld && kind_q == RES_MID) |=> (state_q == S_FETCH))
    else $error("middle result not followed by fetch");

endmodule

`default_nettype wire

// ===== rtl/gcl_dp.sv =====
// datapath: config registers, binning divider, list memories, query walker, output register
// depends on gcl_pkg and gcl_ram
`default_nettype none

module gcl_dp #(
  parameter int unsigned MAX_PARTICLES = gcl_pkg::MaxParticlesDef,
  parameter int unsigned GRID_MAX      = gcl_pkg::GridMaxDef,
  parameter int unsigned BATCH_LIMIT   = gcl_pkg::BatchLimitDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gcl_pkg::req_t in_req_i,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  gcl_pkg::cmd_t cmd_i,
  output gcl_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gcl_pkg::rsp_t out_rsp_o
);

  import gcl_pkg::*;

  localparam int unsigned PW   = $clog2(MAX_PARTICLES);
  localparam int unsigned CNTW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned GW   = $clog2(GRID_MAX);
  localparam int unsigned GGW  = $clog2(GRID_MAX + 1);
  localparam int unsigned CLW  = 2 * GW;
  localparam int unsigned NC   = 1 << CLW;
  localparam int unsigned OAW  = CLW + 1;
  localparam int unsigned IW   = (CNTW > OAW) ? CNTW : OAW;
  localparam int unsigned NW   = 16 + GGW;
  localparam int unsigned KW   = (GW > 1) ? $clog2(GW) : 1;
  localparam int unsigned BW   = $clog2(BATCH_LIMIT + 1);
  localparam int unsigned CMPW = (GGW > 6) ? GGW : 6;
  localparam int unsigned QW   = (CNTW > 12) ? CNTW : 12;

  // config and control registers
  logic [15:0]     span_q;
  logic [5:0]      grid_q;
  logic [CNTW-1:0] count_q;
  logic            built_q;
  logic [3:0]      step_q;
  logic [CNTW-1:0] pos_q;
  logic [BW-1:0]   n_q;
  logic            held_v_q;
  logic            first_q;
  logic            out_valid_q;

  // payload registers
  req_t            req_q;
  logic [NW-1:0]   prod_x_q, prod_y_q, dsh_q;
  logic            clamp_x_q, clamp_y_q;
  logic [GW-1:0]   qx_q, qy_q;
  logic [KW-1:0]   kcnt_q;
  logic [IW-1:0]   idx_q;
  logic [CNTW-1:0] sum_q;
  logic [CLW-1:0]  base_q;
  logic [CNTW-1:0] s_q;
  logic [PW-1:0]   held_q;
  rsp_t            out_q;

  // memory ports
  logic [CLW-1:0]  pc_rdata;
  logic [CNTW-1:0] off_rdata, fill_rdata;
  logic [PW-1:0]   sorted_rdata;
  logic            off_we;
  logic [OAW-1:0]  off_waddr, off_raddr;
  logic [CNTW-1:0] off_wdata;

  // effective grid size and span
  logic [CMPW-1:0] gs_ext;
  logic [GGW-1:0]  g_eff, gm1_full;
  logic [GW-1:0]   gm1, cx, cy;
  logic [15:0]     span_eff;

  assign gs_ext   = CMPW'(grid_q);
  assign g_eff    = (grid_q == 6'd0) ? GGW'(1) :
                    (gs_ext > CMPW'(GRID_MAX)) ? GGW'(GRID_MAX) : gs_ext[GGW-1:0];
  assign span_eff = (span_q == 16'd0) ? 16'd1 : span_q;
  assign gm1_full = g_eff - GGW'(1);
  assign gm1      = gm1_full[GW-1:0];
  assign cx       = clamp_x_q ? gm1 : qx_q;
  assign cy       = clamp_y_q ? gm1 : qy_q;

  // restoring division, one quotient bit per cycle
  logic bit_x, bit_y;
  assign bit_x = (prod_x_q >= dsh_q);
  assign bit_y = (prod_y_q >= dsh_q);

  // neighbor cell of the current step
  logic [1:0]    sx, sy;
  logic [3:0]    sy4;
  logic [GW-1:0] bx, by;
  logic [GW:0]   nxp, nyp, gx, nxm, nym;
  logic [CLW-1:0] ncell;
  logic          on_grid;

  assign sx  = (step_q >= 4'd6) ? 2'd2 : (step_q >= 4'd3) ? 2'd1 : 2'd0;
  assign sy4 = step_q - (4'(sx) * 4'd3);
  assign sy  = sy4[1:0];
  assign bx  = base_q[CLW-1:GW];
  assign by  = base_q[GW-1:0];
  assign nxp = {1'b0, bx} + (GW+1)'(sx);
  assign nyp = {1'b0, by} + (GW+1)'(sy);
  assign gx  = (GW+1)'(g_eff);
  assign nxm = nxp - (GW+1)'(1);
  assign nym = nyp - (GW+1)'(1);
  assign ncell = {nxm[GW-1:0], nym[GW-1:0]};
  assign on_grid = (nxp != '0) && (nyp != '0) && (nxp <= gx) && (nyp <= gx);

  logic [CNTW:0]   spos_w;
  logic [CNTW-1:0] spos;
  logic            found;
  assign spos_w = {1'b0, s_q} + {1'b0, pos_q};
  assign spos   = spos_w[CNTW-1:0];
  assign found  = spos_w < {1'b0, off_rdata};

  // query id check
  logic [QW-1:0] pidx_w;
  logic [PW-1:0] pidx_a;
  assign pidx_w = QW'(req_q.particle_index);
  assign pidx_a = pidx_w[PW-1:0];

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o            = '0;
    sts_o.req_type   = req_q.req_type;
    sts_o.full       = (count_q == CNTW'(MAX_PARTICLES));
    sts_o.q_ok       = built_q && (pidx_w < QW'(count_q));
    sts_o.c_ok       = built_q && (step_q < STEP_IDLE);
    sts_o.div_done   = (kcnt_q == KW'(GW - 1));
    sts_o.idx_eq_cnt = (idx_q == IW'(count_q));
    sts_o.clr_done   = (idx_q == IW'(NC));
    sts_o.pre_done   = (idx_q == IW'(NC - 1));
    sts_o.step_idle  = (step_q >= STEP_IDLE);
    sts_o.on_grid    = on_grid;
    sts_o.found      = found;
    sts_o.held_v     = held_v_q;
    sts_o.at_limit   = (n_q == BW'(BATCH_LIMIT - 1));
    sts_o.out_free   = out_free;
  end

  // memories
  logic [OAW-1:0] pcp1, idxp1, ncell_a, ncellp1;
  assign pcp1    = {1'b0, pc_rdata} + OAW'(1);
  assign idxp1   = idx_q[OAW-1:0] + OAW'(1);
  assign ncell_a = {1'b0, ncell};
  assign ncellp1 = ncell_a + OAW'(1);

  gcl_ram #(.WIDTH(CLW), .DEPTH(MAX_PARTICLES)) u_pc_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_wr),
    .waddr_i (count_q[PW-1:0]),
    .wdata_i ({cx, cy}),
    .re_i    (cmd_i.pc_rd_idx | cmd_i.pc_rd_q),
    .raddr_i (cmd_i.pc_rd_q ? pidx_a : idx_q[PW-1:0]),
    .rdata_o (pc_rdata)
  );

  always_comb begin
    off_we    = cmd_i.off_clr_wr | cmd_i.off_wr_cnt | cmd_i.off_wr_pre;
    off_waddr = cmd_i.off_clr_wr ? idx_q[OAW-1:0] : cmd_i.off_wr_cnt ? pcp1 : idxp1;
    off_wdata = cmd_i.off_clr_wr ? '0 :
                cmd_i.off_wr_cnt ? off_rdata + CNTW'(1) : sum_q + off_rdata;
    off_raddr = cmd_i.off_rd_cnt ? pcp1 :
                cmd_i.off_rd_pre ? idxp1 :
                cmd_i.off_rd_s   ? ncell_a : ncellp1;
  end

  gcl_ram #(.WIDTH(CNTW), .DEPTH(NC + 1)) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .re_i    (cmd_i.off_rd_cnt | cmd_i.off_rd_pre | cmd_i.off_rd_s | cmd_i.off_rd_e),
    .raddr_i (off_raddr),
    .rdata_o (off_rdata)
  );

  gcl_ram #(.WIDTH(CNTW), .DEPTH(NC)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.off_wr_pre | cmd_i.sc_wr),
    .waddr_i (cmd_i.off_wr_pre ? idx_q[CLW-1:0] : pc_rdata),
    .wdata_i (cmd_i.off_wr_pre ? sum_q : fill_rdata + CNTW'(1)),
    .re_i    (cmd_i.fill_rd),
    .raddr_i (pc_rdata),
    .rdata_o (fill_rdata)
  );

  gcl_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_sorted_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sc_wr),
    .waddr_i (fill_rdata[PW-1:0]),
    .wdata_i (idx_q[PW-1:0]),
    .re_i    (cmd_i.fetch),
    .raddr_i (spos[PW-1:0]),
    .rdata_o (sorted_rdata)
  );

  // result formatting
  logic [PW+11:0]   id_w;
  logic [CNTW+12:0] tot_w;
  rsp_t             rsp_d;
  assign id_w  = (PW+12)'(held_q);
  assign tot_w = (CNTW+13)'(count_q);

  always_comb begin
    rsp_d = '0;
    unique case (cmd_i.kind)
      RES_MID: begin
        rsp_d.neighbor_id = id_w[11:0];
        rsp_d.status      = ST_ID;
      end
      RES_LAST_MORE: begin
        rsp_d.neighbor_id  = id_w[11:0];
        rsp_d.status       = ST_ID;
        rsp_d.last         = 1'b1;
        rsp_d.more_pending = 1'b1;
      end
      RES_LAST: begin
        rsp_d.neighbor_id = id_w[11:0];
        rsp_d.status      = ST_ID;
        rsp_d.last        = 1'b1;
      end
      RES_NONE: begin
        rsp_d.status = first_q ? ST_NONE : ST_ERR;
        rsp_d.last   = 1'b1;
      end
      RES_BUILD: begin
        rsp_d.status         = ST_BUILD;
        rsp_d.particle_total = tot_w[12:0];
        rsp_d.last           = 1'b1;
      end
      default: begin
        rsp_d.status = ST_ERR;
        rsp_d.last   = 1'b1;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q      <= SPAN_RST;
      grid_q      <= GRID_RST;
      count_q     <= '0;
      built_q     <= 1'b0;
      step_q      <= '0;
      pos_q       <= '0;
      n_q         <= '0;
      held_v_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SPAN) begin
          span_q <= cfg_data_i;
        end else begin
          grid_q <= cfg_data_i[5:0];
        end
      end
      if (cmd_i.clr || cmd_i.ld_wr) begin
        built_q <= 1'b0;
        step_q  <= STEP_IDLE;
        pos_q   <= '0;
      end
      if (cmd_i.clr) begin
        count_q <= '0;
      end
      if (cmd_i.ld_wr) begin
        count_q <= count_q + CNTW'(1);
      end
      if (cmd_i.build_fin) begin
        built_q <= 1'b1;
        step_q  <= STEP_IDLE;
        pos_q   <= '0;
      end
      if (cmd_i.cap) begin
        n_q      <= '0;
        held_v_q <= 1'b0;
        first_q  <= 1'b0;
      end
      if (cmd_i.q_base) begin
        step_q  <= '0;
        pos_q   <= '0;
        first_q <= 1'b1;
      end
      if (cmd_i.sk_adv) begin
        step_q <= step_q + 4'd1;
        pos_q  <= '0;
      end
      if (cmd_i.fetch) begin
        pos_q <= pos_q + CNTW'(1);
      end
      if (cmd_i.hold) begin
        held_v_q <= 1'b1;
      end
      if (cmd_i.out_ld && cmd_i.kind == RES_MID) begin
        n_q <= n_q + BW'(1);
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q <= in_req_i;
    end
    if (cmd_i.mul) begin
      prod_x_q  <= NW'(req_q.coord_x) * NW'(g_eff);
      prod_y_q  <= NW'(req_q.coord_y) * NW'(g_eff);
      clamp_x_q <= (req_q.coord_x >= span_eff);
      clamp_y_q <= (req_q.coord_y >= span_eff);
      dsh_q     <= NW'(span_eff) << (GW - 1);
      kcnt_q    <= '0;
      qx_q      <= '0;
      qy_q      <= '0;
    end
    if (cmd_i.div) begin
      prod_x_q <= bit_x ? prod_x_q - dsh_q : prod_x_q;
      prod_y_q <= bit_y ? prod_y_q - dsh_q : prod_y_q;
      qx_q     <= GW'({qx_q, bit_x});
      qy_q     <= GW'({qy_q, bit_y});
      dsh_q    <= dsh_q >> 1;
      kcnt_q   <= kcnt_q + KW'(1);
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IW'(1);
    end
    // running prefix sum, restarted before the prefix pass
    if (cmd_i.off_wr_pre) begin
      sum_q <= sum_q + off_rdata;
    end else if (cmd_i.idx_clr) begin
      sum_q <= '0;
    end
    if (cmd_i.q_base) begin
      base_q <= pc_rdata;
    end
    if (cmd_i.off_rd_e) begin
      s_q <= off_rdata;
    end
    if (cmd_i.hold) begin
      held_q <= sorted_rdata;
    end
    if (cmd_i.out_ld) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_i.out_ld)
    else $error("output register overwritten");

  // the particle count never passes capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_PARTICLES))
    else $error("particle count over capacity");

  // a middle result is only emitted with a held id
  a_mid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_ld && cmd_i.kind == RES_MID) |-> held_v_q)
    else $error("middle result without held id");

endmodule

`default_nettype wire

// ===== rtl/grid_cell_list_neighbor_query_unit.sv =====
// top level of the grid cell list neighbor query unit
// depends on gcl_pkg, gcl_ctrl, gcl_dp (which uses gcl_ram)
`default_nettype none

//  channel   handshake                  payload
//  ------    -------------------------  ------------------------------------
//  request   in_valid_i / in_ready_o    in_req_i  (req_type, coords, index)
//  result    out_valid_o / out_ready_i  out_rsp_o (id, status, total, flags)
//  config    cfg_we_i                   cfg_idx_i, cfg_data_i
//
//  one request at a time; a new request is taken once the sequencer is at rest
//  again: after the last result of the previous one is loaded into the output
//  register, or after a clear or an accepted load, which give no result
//  load: bins the coordinates with the bit-serial binning divider, stores the cell
//  build: clears the cell offsets, counts the particles per cell, forms the
//  prefix sums and scatters the ids in cell order; bound by single ram ports
//  query: walks the 3x3 neighbor cells, skipping off-grid ones; output stalls
//  hold the walk; reset clears control state only; no memory clearing pass is needed

module grid_cell_list_neighbor_query_unit #(
  parameter int unsigned MAX_PARTICLES = gcl_pkg::MaxParticlesDef,
  parameter int unsigned GRID_MAX      = gcl_pkg::GridMaxDef,
  parameter int unsigned BATCH_LIMIT   = gcl_pkg::BatchLimitDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gcl_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gcl_pkg::rsp_t out_rsp_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);

  import gcl_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  gcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories: particle cells, cell offsets, fill pointers, sorted ids
  gcl_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .GRID_MAX      (GRID_MAX),
    .BATCH_LIMIT   (BATCH_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire
